@@ rtl/audio_frame_rtp_packetizer_assert.svh @@
// assertion macros for the packetizer checker
`ifndef AUDIO_FRAME_RTP_PACKETIZER_ASSERT_SVH
`define AUDIO_FRAME_RTP_PACKETIZER_ASSERT_SVH

// implication checked on every clock outside reset
`define AFRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afrp check failed");

// next-cycle implication outside reset
`define AFRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afrp check failed");

`endif

@@ rtl/afrp_pkg.sv @@
package afrp_pkg;

    localparam int unsigned MAX_RESULTS = 24;
    localparam int unsigned CNT_W = 5;

    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_AUDIO_KIND  = 2'd1;
    localparam logic [1:0] REG_FPS         = 2'd2;
    localparam logic [1:0] REG_FRAME_DUR   = 2'd3;

    localparam logic KIND_FRAGMENT = 1'b0;
    localparam logic KIND_HINT     = 1'b1;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [13:0] frame_length;
    } afrp_in_t;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] packet_number;
        logic [31:0] frame_number;
        logic [12:0] byte_offset;
        logic [16:0] byte_length;
        logic [2:0]  header_bytes;
        logic        marker;
        logic [31:0] hint_duration;
    } afrp_rec_t;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] packet_number;
        logic [31:0] frame_number;
        logic [12:0] byte_offset;
        logic [16:0] byte_length;
        logic [2:0]  header_bytes;
        logic        marker;
        logic [31:0] hint_duration;
        logic [31:0] peak_bytes_per_second;
        logic        last;
    } afrp_out_t;

    typedef struct packed {
        logic             push;
        afrp_rec_t        rec;
        logic             release_batch;
        logic [CNT_W-1:0] count;
        logic [31:0]      peak;
    } afrp_fb_t;

endpackage

@@ rtl/afrp_front.sv @@
module afrp_front #(
    parameter int unsigned MAX_FRAME_BYTES  = 8192,
    parameter int unsigned RTP_HEADER_BYTES = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  afrp_pkg::afrp_in_t in_data,
    input  logic              back_idle,
    output afrp_pkg::afrp_fb_t fb,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [16:0]       cfg_wdata
);
    import afrp_pkg::*;

    localparam int unsigned LEN_CAP = (MAX_FRAME_BYTES < 16383) ? MAX_FRAME_BYTES : 16383;
    localparam logic [13:0] LEN_CAP_W = 14'(LEN_CAP);
    localparam logic [5:0]  FRAG_LIMIT = 6'(MAX_RESULTS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FRAG = 3'd1;
    localparam logic [2:0] ST_TAIL = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    logic [16:0] maxp_cfg_reg;
    logic        kind_reg;
    logic [7:0]  fps_reg;
    logic [12:0] fdur_reg;

    logic [2:0]  state_reg, state_next;
    logic [16:0] fill_reg, fill_next;
    logic [31:0] pkt_reg, pkt_next;
    logic [15:0] fhint_reg, fhint_next;
    logic [31:0] frame_reg, frame_next;
    logic [7:0]  phase_reg, phase_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] peak_reg, peak_next;
    logic [13:0] len_reg, len_next;
    logic [13:0] pos_reg, pos_next;
    logic [2:0]  fhdr_reg, fhdr_next;
    logic        mk_reg, mk_next;
    logic [CNT_W-1:0] nrec_reg, nrec_next;
    logic [39:0] prod_reg, prod_next;

    logic [16:0] maxp;
    logic [2:0]  hdr;
    logic [8:0]  fps9;
    logic [13:0] len_in;
    logic [16:0] room;
    logic        need_close;
    logic [31:0] dur;
    logic [13:0] rem;
    logic [16:0] chunk;
    logic [13:0] next_pos;
    logic        frag_done;
    logic        big;
    logic        tail_hint;
    logic [7:0]  phase_inc;
    logic [39:0] sum;
    logic [31:0] sat;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxp_cfg_reg <= 17'd1460;
            kind_reg     <= 1'b0;
            fps_reg      <= 8'd43;
            fdur_reg     <= 13'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_PAYLOAD: maxp_cfg_reg <= cfg_wdata;
                REG_AUDIO_KIND:  kind_reg     <= cfg_wdata[0];
                REG_FPS:         fps_reg      <= cfg_wdata[7:0];
                REG_FRAME_DUR:   fdur_reg     <= cfg_wdata[12:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (maxp_cfg_reg < 17'd512)
            maxp = 17'd512;
        else if (maxp_cfg_reg > 17'h10000)
            maxp = 17'h10000;
        else
            maxp = maxp_cfg_reg;
        hdr        = kind_reg ? 3'd4 : 3'd2;
        fps9       = (fps_reg == 8'd0) ? 9'd1 : {1'b0, fps_reg};
        len_in     = (in_data.frame_length > LEN_CAP_W) ? LEN_CAP_W : in_data.frame_length;
        room       = (fill_reg < maxp) ? (maxp - fill_reg) : 17'd0;
        need_close = (fill_reg != 17'd0) && (({3'b0, len_in} + {14'b0, hdr}) > room);
        dur        = 32'({16'b0, fhint_reg} * {19'b0, fdur_reg});
        rem        = len_reg - pos_reg;
        chunk      = ({3'b0, rem} < room) ? {3'b0, rem} : room;
        next_pos   = pos_reg + chunk[13:0];
        frag_done  = (next_pos >= len_reg) || ({1'b0, nrec_reg} + 6'd1 >= FRAG_LIMIT);
        big        = ({3'b0, len_reg} + {14'b0, hdr}) > maxp;
        tail_hint  = big || (fill_reg == 17'd0);
        phase_inc  = ({1'b0, phase_reg} + 9'd1 >= fps9) ? 8'd0 : phase_reg + 8'd1;
        sum        = prod_reg + {8'b0, bytes_reg};
        sat        = (sum[39:32] != 8'd0) ? 32'hFFFF_FFFF : sum[31:0];
        accept     = in_valid && in_ready;
    end

    assign in_ready = (state_reg == ST_IDLE) && back_idle;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pkt_next   = pkt_reg;
        fhint_next = fhint_reg;
        frame_next = frame_reg;
        phase_next = phase_reg;
        bytes_next = bytes_reg;
        start_next = start_reg;
        peak_next  = peak_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        fhdr_next  = fhdr_reg;
        mk_next    = mk_reg;
        nrec_next  = nrec_reg;
        prod_next  = prod_reg;
        fb         = '0;
        fb.peak    = peak_reg;
        fb.count   = nrec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_FLUSH)
                    begin
                        fb.release_batch = 1'b1;
                        if (fill_reg != 17'd0)
                        begin
                            fb.push                  = 1'b1;
                            fb.rec.record_kind       = KIND_HINT;
                            fb.rec.hint_duration     = dur;
                            fb.count                 = CNT_W'(1);
                            fhint_next               = 16'd0;
                            pkt_next                 = pkt_reg + 32'd1;
                            fill_next                = 17'd0;
                        end
                        else
                        begin
                            fb.count = '0;
                        end
                    end
                    else
                    begin
                        bytes_next = bytes_reg + {18'b0, len_in};
                        len_next   = len_in;
                        pos_next   = 14'd0;
                        fhdr_next  = hdr;
                        mk_next    = 1'b1;
                        if (need_close)
                        begin
                            fb.push              = 1'b1;
                            fb.rec.record_kind   = KIND_HINT;
                            fb.rec.hint_duration = dur;
                            pkt_next             = pkt_reg + 32'd1;
                            fill_next            = {14'b0, hdr};
                            fhint_next           = 16'd1;
                            nrec_next            = CNT_W'(1);
                        end
                        else
                        begin
                            fill_next  = fill_reg + {14'b0, hdr};
                            fhint_next = fhint_reg + 16'd1;
                            nrec_next  = '0;
                        end
                        state_next = ST_FRAG;
                    end
                end
            end
            ST_FRAG:
            begin
                fb.push                  = 1'b1;
                fb.rec.record_kind       = KIND_FRAGMENT;
                fb.rec.packet_number     = pkt_reg;
                fb.rec.frame_number      = frame_reg;
                fb.rec.byte_offset       = pos_reg[12:0];
                fb.rec.byte_length       = chunk;
                fb.rec.header_bytes      = fhdr_reg;
                fb.rec.marker            = mk_reg;
                nrec_next                = nrec_reg + CNT_W'(1);
                fill_next                = fill_reg + chunk;
                if (frag_done)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    pkt_next  = pkt_reg + 32'd1;
                    fill_next = kind_reg ? 17'd4 : 17'd0;
                    fhdr_next = kind_reg ? 3'd4 : 3'd0;
                    mk_next   = 1'b0;
                    pos_next  = next_pos;
                end
            end
            ST_TAIL:
            begin
                if (big)
                begin
                    pkt_next  = pkt_reg + 32'd1;
                    fill_next = 17'd0;
                end
                if (tail_hint)
                begin
                    fb.push              = 1'b1;
                    fb.rec.record_kind   = KIND_HINT;
                    fb.rec.hint_duration = dur;
                    fhint_next           = 16'd0;
                    nrec_next            = nrec_reg + CNT_W'(1);
                end
                frame_next = frame_reg + 32'd1;
                phase_next = phase_inc;
                if (phase_inc == 8'd0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    fb.release_batch = 1'b1;
                    fb.count         = tail_hint ? nrec_reg + CNT_W'(1) : nrec_reg;
                    state_next       = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next  = {8'b0, pkt_reg - start_reg} * 40'(RTP_HEADER_BYTES);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (sat > peak_reg)
                    peak_next = sat;
                bytes_next       = 32'd0;
                start_next       = pkt_reg;
                fb.release_batch = 1'b1;
                fb.peak          = (sat > peak_reg) ? sat : peak_reg;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= 17'd0;
            pkt_reg   <= 32'd2;
            fhint_reg <= 16'd0;
            frame_reg <= 32'd1;
            phase_reg <= 8'd1;
            bytes_reg <= 32'd0;
            start_reg <= 32'd1;
            peak_reg  <= 32'd0;
            nrec_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pkt_reg   <= pkt_next;
            fhint_reg <= fhint_next;
            frame_reg <= frame_next;
            phase_reg <= phase_next;
            bytes_reg <= bytes_next;
            start_reg <= start_next;
            peak_reg  <= peak_next;
            nrec_reg  <= nrec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        fhdr_reg <= fhdr_next;
        mk_reg   <= mk_next;
        prod_reg <= prod_next;
    end

endmodule

@@ rtl/afrp_back.sv @@
module afrp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  afrp_pkg::afrp_fb_t fb,
    output logic               back_idle,
    output logic               out_valid,
    input  logic               out_ready,
    output afrp_pkg::afrp_out_t out_data
);
    import afrp_pkg::*;

    localparam int unsigned DEPTH = 2 ** CNT_W;

    afrp_rec_t        mem [DEPTH];
    logic [CNT_W-1:0] wptr_reg;
    logic [CNT_W-1:0] rptr_reg;
    logic [CNT_W-1:0] remain_reg;
    logic             ov_reg;
    afrp_out_t        out_reg;
    afrp_rec_t        head;
    logic             pop;

    assign head      = mem[rptr_reg];
    assign pop       = (remain_reg != '0) && (!ov_reg || out_ready);
    assign back_idle = (remain_reg == '0);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // record queue
    always_ff @(posedge clk)
    begin
        if (fb.push)
            mem[wptr_reg] <= fb.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            remain_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (fb.push)
                wptr_reg <= wptr_reg + CNT_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + CNT_W'(1);
            if (fb.release_batch)
                remain_reg <= fb.count;
            else if (pop)
                remain_reg <= remain_reg - CNT_W'(1);
            if (pop)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.record_kind           <= head.record_kind;
            out_reg.packet_number         <= head.packet_number;
            out_reg.frame_number          <= head.frame_number;
            out_reg.byte_offset           <= head.byte_offset;
            out_reg.byte_length           <= head.byte_length;
            out_reg.header_bytes          <= head.header_bytes;
            out_reg.marker                <= head.marker;
            out_reg.hint_duration         <= head.hint_duration;
            out_reg.peak_bytes_per_second <= fb.peak;
            out_reg.last                  <= (remain_reg == CNT_W'(1));
        end
    end

endmodule

@@ rtl/audio_frame_rtp_packetizer.sv @@
// channel   dir   handshake              beat
// in        in    in_valid / in_ready    mode, frame_length
// out       out   out_valid / out_ready  one fragment or hint record
// cfg       in    cfg_we                 cfg_addr selects register, cfg_wdata
//
// a frame: idle, fragment state per record, tail; mul and sum at a window end
// records drain one per cycle unless out stalls; next item waits for the drain
// a flush is handled in the idle state without leaving it
// rst_n clears all stream state to its start values, no clearing pass
// out stalls hold the record queue; in_ready stays low until its batch is out
module audio_frame_rtp_packetizer #(
    parameter int unsigned MAX_FRAME_BYTES  = 8192,
    parameter int unsigned RTP_HEADER_BYTES = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  afrp_pkg::afrp_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output afrp_pkg::afrp_out_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [16:0]         cfg_wdata
);
    import afrp_pkg::*;

    afrp_fb_t fb;
    logic     back_idle;

    afrp_front #(
        .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
        .RTP_HEADER_BYTES (RTP_HEADER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .back_idle (back_idle),
        .fb        (fb),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    afrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fb        (fb),
        .back_idle (back_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/afrp_checker.sv @@
`include "audio_frame_rtp_packetizer_assert.svh"

module afrp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input afrp_pkg::afrp_out_t out_data
);
    import afrp_pkg::*;

    `AFRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `AFRP_ASSERT_IMP(a_no_take_mid_batch, out_valid && !out_data.last, !in_ready)
    `AFRP_ASSERT_IMP(a_hint_clean, out_valid && out_data.record_kind == KIND_HINT, out_data.packet_number == 32'd0 && out_data.byte_length == 17'd0)
    `AFRP_ASSERT_IMP(a_hdr_size, out_valid && out_data.record_kind == KIND_FRAGMENT, out_data.header_bytes == 3'd0 || out_data.header_bytes == 3'd2 || out_data.header_bytes == 3'd4)

endmodule

bind audio_frame_rtp_packetizer afrp_checker u_afrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
